>>> sv/sbcs_pkg.sv
// shared types and constants of the strike bucket coupon selector
package sbcs_pkg;

  // field and port widths
  localparam int VAL_W      = 32;
  localparam int POS_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SPREAD_W   = 31;
  localparam int COUNT_W    = 3;
  localparam int STRIKE_REGS = 4;
  localparam int STRIKE_IDX_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_COUNT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SPREAD = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CALL_SPREAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_W    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE_N    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE0     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE3     = 3'd6;

  typedef logic signed [VAL_W-1:0] value_t;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic               start;
    logic [VAL_W-1:0]   mcand;
    logic [VAL_W-1:0]   mplier;
    logic [VAL_W-1:0]   divisor;
  } md_req_t;

  // response of the shared multiply/divide unit
  typedef struct packed {
    logic               done;
    logic [VAL_W-1:0]   quot;
  } md_rsp_t;

endpackage

>>> sv/sbcs_in_if.sv
// element request channel of the coupon selector
interface sbcs_in_if;
  import sbcs_pkg::*;

  logic         valid;
  logic         ready;
  value_t       element_value;
  logic         last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

>>> sv/sbcs_out_if.sv
// result request channel of the coupon selector
interface sbcs_out_if;
  import sbcs_pkg::*;

  logic                 valid;
  logic                 ready;
  value_t               coupon_value;
  logic [POS_W-1:0]     selected_position;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, output coupon_value, output selected_position,
                  output status, input ready);
  modport sink   (input valid, input coupon_value, input selected_position,
                  input status, output ready);
endinterface

>>> sv/sbcs_ram.sv
// generic single write, single read ram with registered read data
module sbcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sbcs_muldiv.sv
// shared shift-add multiplier followed by restoring divider, one bit per cycle
module sbcs_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  sbcs_pkg::md_req_t req,
  output sbcs_pkg::md_rsp_t rsp
);
  import sbcs_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]           phase_r;
  logic [5:0]           step_r;
  logic [2*VAL_W-1:0]   acc_r;
  logic [2*VAL_W-1:0]   mc_r;
  logic [VAL_W-1:0]     mp_r;
  logic [VAL_W-1:0]     rem_r;
  logic [VAL_W-1:0]     dv_r;
  logic                 done_r;

  logic [2*VAL_W-1:0]   sum;
  logic [VAL_W+1:0]     trial;
  logic                 qbit;
  logic [VAL_W-1:0]     rem_nxt;

  // partial product add and trial subtract
  always_comb begin
    sum     = acc_r + mc_r;
    trial   = {1'b0, rem_r, acc_r[2*VAL_W-1]} - {2'b00, dv_r};
    qbit    = !trial[VAL_W+1];
    rem_nxt = qbit ? trial[VAL_W-1:0] : {rem_r[VAL_W-2:0], acc_r[2*VAL_W-1]};
  end

  // sequencer: 32 multiply steps then 64 divide steps, acc holds product then quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == PH_DIV) && (step_r == 6'd63);
      case (phase_r)
        PH_IDLE: begin
          if (req.start) begin
            mc_r    <= {{VAL_W{1'b0}}, req.mcand};
            mp_r    <= req.mplier;
            dv_r    <= req.divisor;
            acc_r   <= '0;
            step_r  <= '0;
            phase_r <= PH_MUL;
          end
        end
        PH_MUL: begin
          if (mp_r[0]) begin
            acc_r <= sum;
          end
          mc_r   <= mc_r << 1;
          mp_r   <= mp_r >> 1;
          if (step_r == 6'd31) begin
            step_r  <= '0;
            rem_r   <= '0;
            phase_r <= PH_DIV;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        PH_DIV: begin
          acc_r  <= {acc_r[2*VAL_W-2:0], qbit};
          rem_r  <= rem_nxt;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) begin
            phase_r <= PH_IDLE;
          end
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = acc_r[VAL_W-1:0];

endmodule

>>> sv/strike_bucket_coupon_select_core.sv
// strike bucket coupon selector: element intake, strike scan and result sequencer
// An unmarked element is taken while the sequencer is idle. A marked element closes
// the call: the sequencer checks it, scans the strikes and reads the bucket coupons,
// and when interpolating it waits on the 32 multiply and 64 divide steps of
// the shared mul/div unit. A result waits in the output register while
// elements of the next call are taken. Reset clears control and configuration;
// the coupon store is undefined until written.
module strike_bucket_coupon_select_core #(
  parameter int MAX_STRIKES = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sbcs_in_if.sink                          in_chan,
  sbcs_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [sbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbcs_pkg::*;

  localparam int SLOTS = MAX_STRIKES + 2;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CHECK   = 4'd1;
  localparam logic [3:0] ST_SCAN    = 4'd2;
  localparam logic [3:0] ST_RESOLVE = 4'd3;
  localparam logic [3:0] ST_RD_LO   = 4'd4;
  localparam logic [3:0] ST_RD_HI   = 4'd5;
  localparam logic [3:0] ST_PREP    = 4'd6;
  localparam logic [3:0] ST_MULDIV  = 4'd7;
  localparam logic [3:0] ST_FINISH  = 4'd8;

  // configuration
  logic                  spread_on_r;
  logic [SPREAD_W-1:0]   spread_w_r;
  logic [COUNT_W-1:0]    strike_n_r;
  value_t                strike_r [STRIKE_REGS];

  // call and sequencer state
  logic [3:0]             state_r, state_nxt;
  value_t                 base_r;
  logic [CW-1:0]          cnt_r;
  logic                   ovf_r;
  logic [STRIKE_IDX_W-1:0] idx_r;
  value_t                 prev_r;
  logic                   found_r;
  logic                   interp_r;
  logic                   bad_r;
  logic [POS_W-1:0]       sel_pos_r;
  logic [VAL_W-1:0]       t_r;
  value_t                 lo_r;
  logic [VAL_W-1:0]       mag_r;
  logic                   neg_r;
  logic                   md_start_r;
  value_t                 res_coupon_r;
  logic [POS_W-1:0]       res_pos_r;
  logic [STATUS_W-1:0]    res_status_r;

  // output register
  logic                   ov_r;
  value_t                 oc_r;
  logic [POS_W-1:0]       op_r;
  logic [STATUS_W-1:0]    os_r;

  logic                   in_fire;
  logic                   out_free;
  logic [STATUS_W-1:0]    chk_status;
  value_t                 cur_strike;
  logic signed [VAL_W+1:0] b2, s2, wz, lo_lim, hi_lim, tt;
  logic                   last_idx;
  logic [POS_W-1:0]       idx_pos;
  logic [POS_W-1:0]       pos_inc;
  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [VAL_W-1:0]       ram_rdata;
  logic signed [VAL_W:0]  d33, dmag33;
  logic signed [VAL_W+1:0] step34, sum34;
  value_t                 sat_res;
  md_req_t                md_req;
  md_rsp_t                md_rsp;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !ov_r || out_chan.ready;

  // call checks ahead of the scan
  always_comb begin
    if (spread_on_r && spread_w_r == '0) begin
      chk_status = STATUS_SPREAD;
    end else if (strike_n_r > COUNT_W'(MAX_STRIKES) || ovf_r ||
                 4'(cnt_r) != 4'(strike_n_r) + 4'd2) begin
      chk_status = STATUS_COUNT;
    end else begin
      chk_status = STATUS_OK;
    end
  end

  // strike compare unit, one strike per scan cycle
  always_comb begin
    cur_strike = strike_r[idx_r];
    b2       = {base_r[VAL_W-1], base_r, 1'b0};
    s2       = {cur_strike[VAL_W-1], cur_strike, 1'b0};
    wz       = {3'b000, spread_w_r};
    lo_lim   = s2 - wz;
    hi_lim   = s2 + wz;
    tt       = b2 - lo_lim;
    last_idx = {1'b0, idx_r} == strike_n_r - 3'd1;
    idx_pos  = {1'b0, idx_r} + 3'd1;
    pos_inc  = sel_pos_r + 3'd1;
  end

  // coupon difference and saturated interpolation sum
  always_comb begin
    d33    = {ram_rdata[VAL_W-1], ram_rdata} - {lo_r[VAL_W-1], lo_r};
    dmag33 = d33[VAL_W] ? -d33 : d33;
    step34 = neg_r ? -$signed({2'b00, md_rsp.quot}) : $signed({2'b00, md_rsp.quot});
    sum34  = {{2{lo_r[VAL_W-1]}}, lo_r} + step34;
    if (sum34[VAL_W+1:VAL_W-1] == 3'b000 || sum34[VAL_W+1:VAL_W-1] == 3'b111) begin
      sat_res = sum34[VAL_W-1:0];
    end else if (sum34[VAL_W+1]) begin
      sat_res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // coupon store
  assign ram_we    = in_fire && cnt_r < CW'(SLOTS);
  assign ram_raddr = (state_r == ST_RD_LO) ? sel_pos_r[AW-1:0] : pos_inc[AW-1:0];

  sbcs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_chan.element_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiply/divide: |c_hi - c_lo| * t / (2 * width)
  assign md_req.start   = md_start_r;
  assign md_req.mcand   = mag_r;
  assign md_req.mplier  = t_r;
  assign md_req.divisor = {spread_w_r, 1'b0};

  sbcs_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_chan.last_element) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_status != STATUS_OK) begin
          state_nxt = ST_FINISH;
        end else if (strike_n_r == '0) begin
          state_nxt = ST_RESOLVE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: state_nxt = bad_r ? ST_FINISH : ST_RD_LO;
      ST_RD_LO:   state_nxt = ST_RD_HI;
      ST_RD_HI:   state_nxt = interp_r ? ST_PREP : ST_FINISH;
      ST_PREP:    state_nxt = ST_MULDIV;
      ST_MULDIV: begin
        if (md_rsp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_on_r <= 1'b0;
      spread_w_r  <= '0;
      strike_n_r  <= '0;
      for (int k = 0; k < STRIKE_REGS; k++) begin
        strike_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CALL_SPREAD: spread_on_r <= cfg_data[0];
        REG_SPREAD_W:    spread_w_r  <= cfg_data[SPREAD_W-1:0];
        REG_STRIKE_N:    strike_n_r  <= cfg_data[COUNT_W-1:0];
        REG_STRIKE0:     strike_r[0] <= cfg_data;
        REG_STRIKE1:     strike_r[1] <= cfg_data;
        REG_STRIKE2:     strike_r[2] <= cfg_data;
        REG_STRIKE3:     strike_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // element intake, scan and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      base_r     <= '0;
      md_start_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      md_start_r <= (state_r == ST_PREP);
      // output valid: load a finished result, clear once taken
      if (state_r == ST_FINISH && out_free) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_chan.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (cnt_r < CW'(SLOTS)) begin
              if (cnt_r == '0) begin
                base_r <= in_chan.element_value;
              end
              cnt_r <= cnt_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          idx_r        <= '0;
          found_r      <= 1'b0;
          interp_r     <= 1'b0;
          bad_r        <= 1'b0;
          res_coupon_r <= '0;
          res_pos_r    <= '0;
          res_status_r <= chk_status;
        end
        ST_SCAN: begin
          prev_r <= cur_strike;
          idx_r  <= idx_r + STRIKE_IDX_W'(1);
          if (idx_r != '0 && prev_r > cur_strike) begin
            bad_r <= 1'b1;
          end
          if (!found_r) begin
            if (!spread_on_r) begin
              if (base_r < cur_strike) begin
                found_r   <= 1'b1;
                sel_pos_r <= idx_pos;
              end
            end else if (b2 < lo_lim) begin
              found_r   <= 1'b1;
              sel_pos_r <= idx_pos;
            end else if (b2 <= hi_lim) begin
              found_r   <= 1'b1;
              interp_r  <= 1'b1;
              sel_pos_r <= idx_pos;
              t_r       <= tt[VAL_W-1:0];
            end
          end
        end
        ST_RESOLVE: begin
          if (bad_r) begin
            res_status_r <= STATUS_ORDER;
          end else if (!found_r) begin
            sel_pos_r <= strike_n_r + 3'd1;
            interp_r  <= 1'b0;
          end
        end
        ST_RD_HI: begin
          lo_r         <= ram_rdata;
          res_coupon_r <= ram_rdata;
          res_pos_r    <= sel_pos_r;
        end
        ST_PREP: begin
          mag_r <= dmag33[VAL_W-1:0];
          neg_r <= d33[VAL_W];
        end
        ST_MULDIV: begin
          if (md_rsp.done) begin
            res_coupon_r <= sat_res;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            oc_r  <= res_coupon_r;
            op_r  <= res_pos_r;
            os_r  <= res_status_r;
            cnt_r <= '0;
            ovf_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ports
  assign in_chan.ready              = (state_r == ST_IDLE);
  assign out_chan.valid             = ov_r;
  assign out_chan.coupon_value      = oc_r;
  assign out_chan.selected_position = op_r;
  assign out_chan.status            = os_r;

  // checks on the sequencer and result formation
  a_md_done_in_muldiv: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> state_r == ST_MULDIV)
    else $error("mul/div completion outside its wait state");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && os_r != STATUS_OK |-> oc_r == '0 && op_r == '0)
    else $error("error result with non-zero coupon or position");

  a_ok_has_position: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && os_r == STATUS_OK |-> op_r != '0)
    else $error("ok result without a coupon position");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS))
    else $error("element count past the store depth");

endmodule

>>> tb/tb_strike_bucket_coupon_select_core.sv
// testbench of the strike bucket coupon selector: scoreboard class, request drivers and phases
module tb_strike_bucket_coupon_select_core;
  import sbcs_pkg::*;

  localparam int     MAX_STRIKES   = 4;
  localparam int     ELEM_SLOTS    = MAX_STRIKES + 2;
  localparam int     CFG_REGS      = 7;
  localparam int     CALL_BUF      = 8;
  localparam int     SETTLE_CYCLES = 160;
  localparam int     HOLD_CYCLES   = 600;
  localparam int     PHASES        = 16;
  localparam int     PHASE_ITEMS   = 118;
  localparam int     PRESSURE_PHASE = 4;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     REPORT_LIMIT  = 10;
  localparam value_t VAL_HI        = 32'h7fff_ffff;
  localparam value_t VAL_LO        = 32'h8000_0000;
  localparam longint VAL_MAX       = 64'sd2147483647;
  localparam longint VAL_MIN       = -64'sd2147483648;

  // one expected result of a call
  typedef struct packed {
    value_t               coupon;
    logic [POS_W-1:0]     pos;
    logic [STATUS_W-1:0]  status;
  } payoff_t;

  // coupon predictor and expected payoff store
  class payoff_scoreboard;
    bit                 spread_on;
    bit [SPREAD_W-1:0]  spread;
    bit [COUNT_W-1:0]   nstrikes;
    value_t             strike [STRIKE_REGS];
    value_t             base;
    value_t             slot [ELEM_SLOTS];
    int                 count;
    bit                 overflow;
    payoff_t            expected_payoffs [$];
    int                 mismatches;

    function new();
      spread_on  = 1'b0;
      spread     = '0;
      nstrikes   = '0;
      base       = '0;
      count      = 0;
      overflow   = 1'b0;
      mismatches = 0;
      foreach (strike[k]) strike[k] = '0;
      foreach (slot[k]) slot[k] = '0;
    endfunction

    // keep a copy of each register write
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CALL_SPREAD: spread_on = data[0];
        REG_SPREAD_W:    spread    = data[SPREAD_W-1:0];
        REG_STRIKE_N:    nstrikes  = data[COUNT_W-1:0];
        REG_STRIKE0:     strike[0] = data;
        REG_STRIKE1:     strike[1] = data;
        REG_STRIKE2:     strike[2] = data;
        REG_STRIKE3:     strike[3] = data;
        default: ;
      endcase
    endfunction

    // take in one accepted element, predict the payoff when the call closes
    function void note_element(value_t v, logic last);
      payoff_t    p;
      bit         done;
      longint     b2, s2, w, d, sum;
      bit [63:0]  mag, t, q, twice_w;
      if (count < ELEM_SLOTS) begin
        if (count == 0) base = v;
        slot[count] = v;
        count++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;

      // error checks in order of precedence
      p    = '0;
      done = 1'b0;
      if (spread_on && spread == '0) begin
        p.status = STATUS_SPREAD;
      end else if (int'(nstrikes) > MAX_STRIKES || overflow || count != int'(nstrikes) + 2) begin
        p.status = STATUS_COUNT;
      end else begin
        for (int k = 1; k < int'(nstrikes); k++)
          if (strike[k-1] > strike[k]) p.status = STATUS_ORDER;
      end

      // bucket scan, at doubled scale in call-spread mode
      if (p.status == STATUS_OK) begin
        w       = longint'(spread);
        b2      = 2 * longint'(base);
        twice_w = 64'(spread) << 1;
        for (int k = 0; k < int'(nstrikes) && !done; k++) begin
          s2 = 2 * longint'(strike[k]);
          if (!spread_on) begin
            if (base < strike[k]) begin
              p.pos    = POS_W'(k + 1);
              p.coupon = slot[k+1];
              done     = 1'b1;
            end
          end else if (b2 < s2 - w) begin
            p.pos    = POS_W'(k + 1);
            p.coupon = slot[k+1];
            done     = 1'b1;
          end else if (b2 <= s2 + w) begin
            // linear blend across the spread, quotient truncated toward zero
            d   = longint'(slot[k+2]) - longint'(slot[k+1]);
            mag = (d < 0) ? 64'(-d) : 64'(d);
            t   = 64'(b2 - s2 + w);
            q   = (mag * t) / twice_w;
            sum = longint'(slot[k+1]) + ((d < 0) ? -longint'(q) : longint'(q));
            if (sum > VAL_MAX) sum = VAL_MAX;
            else if (sum < VAL_MIN) sum = VAL_MIN;
            p.pos    = POS_W'(k + 1);
            p.coupon = sum[31:0];
            done     = 1'b1;
          end
        end
        if (!done) begin
          p.pos    = POS_W'(int'(nstrikes) + 1);
          p.coupon = slot[(int'(nstrikes) + 1) % ELEM_SLOTS];
        end
      end
      expected_payoffs.push_back(p);
      count    = 0;
      overflow = 1'b0;
    endfunction

    // compare one result with the oldest expected payoff
    function void check_payoff(value_t coupon, logic [POS_W-1:0] pos,
                               logic [STATUS_W-1:0] status);
      payoff_t e;
      if (expected_payoffs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with none expected: coupon %h position %0d status %0d",
                   coupon, pos, status);
        return;
      end
      e = expected_payoffs.pop_front();
      if (coupon !== e.coupon || pos !== e.pos || status !== e.status) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result differs: expected coupon %h position %0d status %0d, got %h %0d %0d",
                   e.coupon, e.pos, e.status, coupon, pos, status);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     idle_pct = 0;
  int                     stall_pct = 0;
  bit                     hold_request = 1'b0;
  value_t                 call_buf [CALL_BUF];
  payoff_scoreboard       sb;

  sbcs_in_if  in_if ();
  sbcs_out_if out_if ();

  strike_bucket_coupon_select_core #(
    .MAX_STRIKES (MAX_STRIKES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one element request, with a random gap ahead of it
  task automatic send_element(input value_t v, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.element_value <= v;
    in_if.last_element  <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_element(v, last);
  endtask

  // send the first n elements of the call buffer, the last one marked
  task automatic send_call(input int n);
    for (int k = 0; k < n; k++)
      send_element(call_buf[k], k == n - 1);
  endtask

  // stop offering, wait for every payoff, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_payoffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write every register, one per cycle
  task automatic apply_config(input bit on, input bit [SPREAD_W-1:0] width,
                              input bit [COUNT_W-1:0] n,
                              input value_t s0, input value_t s1,
                              input value_t s2, input value_t s3);
    logic [CFG_IDX_W-1:0]  idx  [CFG_REGS];
    logic [CFG_DATA_W-1:0] data [CFG_REGS];
    idx  = '{REG_CALL_SPREAD, REG_SPREAD_W, REG_STRIKE_N,
             REG_STRIKE0, REG_STRIKE1, REG_STRIKE2, REG_STRIKE3};
    data = '{CFG_DATA_W'(on), CFG_DATA_W'(width), CFG_DATA_W'(n), s0, s1, s2, s3};
    foreach (idx[k]) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= data[k];
      @(posedge clk);
      sb.write_reg(idx[k], data[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: check accepted payoffs, random stalls, one long hold-off
  initial begin : result_sink
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_payoff(out_if.coupon_value, out_if.selected_position, out_if.status);
      if (hold_request && !hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // cycle counter guarding against a hang
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("strike_bucket_coupon_select_core: mismatch");
    $finish;
  end

  // stimulus: directed calls, then random phases
  initial begin : stimulus
    bit                 on;
    bit [SPREAD_W-1:0]  width;
    bit [COUNT_W-1:0]   n;
    value_t             s [STRIKE_REGS];
    value_t             tmp;
    longint             at, off, pick;
    int                 mode, r, which, n_elems, phase_items;
    sb = new();
    in_if.valid         <= 1'b0;
    in_if.element_value <= '0;
    in_if.last_element  <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    rst_n               <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no strikes: last coupon, field extremes
    call_buf[0] = VAL_HI;
    call_buf[1] = VAL_LO;
    send_call(2);
    // too many elements, tail dropped
    for (int k = 0; k < 7; k++) call_buf[k] = value_t'(32'(k) << 16);
    send_call(7);
    // call cut short
    call_buf[0] = '0;
    send_call(1);
    drain();

    // call spread with zero width
    apply_config(1'b1, '0, '0, '0, '0, '0, '0);
    call_buf[0] = 32'h0001_0000;
    call_buf[1] = 32'h0002_0000;
    send_call(2);
    drain();

    // base right on a strike, halfway between extreme coupons
    apply_config(1'b1, SPREAD_W'(32'h0002_0000), COUNT_W'(2), '0, 32'h0001_0000, '0, '0);
    call_buf[0] = '0;
    call_buf[1] = VAL_HI;
    call_buf[2] = VAL_LO;
    call_buf[3] = '0;
    send_call(4);
    drain();

    // strikes out of order
    apply_config(1'b0, SPREAD_W'(32'h0002_0000), COUNT_W'(2), 32'h0001_0000, '0, '0, '0);
    send_call(4);
    drain();

    // step bucket below the single strike
    apply_config(1'b0, '0, COUNT_W'(1), '0, '0, '0, '0);
    call_buf[0] = 32'hffff_ffff;
    call_buf[1] = 32'h0003_0000;
    call_buf[2] = 32'h0004_0000;
    send_call(3);
    drain();

    // strike count above the supported maximum
    apply_config(1'b0, '0, COUNT_W'(MAX_STRIKES + 1), '0, '0, '0, '0);
    send_call(2);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      hold_request = (phase == PRESSURE_PHASE);

      // random setting
      on   = 1'($urandom_range(0, 1));
      mode = int'($urandom_range(0, 99));
      if (mode < 5) width = '0;
      else if (mode < 10) width = SPREAD_W'(1);
      else if (mode < 15) width = '1;
      else if (mode < 35) width = SPREAD_W'($urandom);
      else width = SPREAD_W'($urandom_range(2, 1 << 18));
      if ($urandom_range(0, 99) < 85) n = COUNT_W'($urandom_range(0, MAX_STRIKES));
      else n = COUNT_W'($urandom_range(MAX_STRIKES + 1, 7));
      mode = int'($urandom_range(0, 9));
      if (mode <= 5) begin
        // close ordered strikes, now and then two equal
        at = longint'($urandom_range(0, 1 << 21)) - (64'sd1 << 20);
        foreach (s[k]) begin
          s[k] = at[31:0];
          if ($urandom_range(0, 3) != 0) at += longint'($urandom_range(1, 1 << 18));
        end
      end else begin
        // full range strikes, sorted except in the last mode
        foreach (s[k]) s[k] = $urandom;
        if (mode <= 8)
          for (int a = 0; a < STRIKE_REGS - 1; a++)
            for (int b = 0; b < STRIKE_REGS - 1 - a; b++)
              if (s[b] > s[b+1]) begin
                tmp    = s[b];
                s[b]   = s[b+1];
                s[b+1] = tmp;
              end
      end
      // corner settings in the first phases
      case (phase)
        0: begin
          on    = 1'b1;
          width = '1;
          n     = COUNT_W'(MAX_STRIKES);
          s     = '{VAL_LO, 32'hffff_ffff, '0, VAL_HI};
        end
        1: begin
          on = 1'b0;
          n  = COUNT_W'(MAX_STRIKES);
          s  = '{VAL_LO, VAL_LO, VAL_HI, VAL_HI};
        end
        2: begin
          on    = 1'b1;
          width = SPREAD_W'(1);
        end
        3: n = '0;
        default: ;
      endcase
      apply_config(on, width, n, s[0], s[1], s[2], s[3]);

      // idling mix of this phase
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // mostly well-formed calls, some with a wrong length
        r = int'($urandom_range(0, 99));
        if (r < 85 && int'(sb.nstrikes) <= MAX_STRIKES) n_elems = int'(sb.nstrikes) + 2;
        else n_elems = int'($urandom_range(1, CALL_BUF));
        which = int'($urandom_range(0, STRIKE_REGS - 1));
        r     = int'($urandom_range(0, 99));
        if (r < 50) begin
          // inside or just outside the spread around one strike
          off = longint'(sb.spread) / 2 + 4;
          if (off > (64'sd1 << 30)) off = 64'sd1 << 30;
          pick = longint'(sb.strike[which]) + longint'($urandom_range(0, 32'(2 * off))) - off;
        end else if (r < 70) begin
          // on the edge of the spread or one step past it
          off  = longint'(sb.spread) / 2 + longint'($urandom_range(0, 1));
          pick = longint'(sb.strike[which]) + (($urandom_range(0, 1) == 0) ? off : -off);
        end else begin
          pick = longint'(value_t'($urandom));
        end
        if (pick > VAL_MAX) pick = VAL_MAX;
        else if (pick < VAL_MIN) pick = VAL_MIN;
        call_buf[0] = pick[31:0];
        for (int k = 1; k < n_elems; k++)
          if ($urandom_range(0, 9) < 7) call_buf[k] = $urandom;
          else call_buf[k] = value_t'($urandom_range(0, 1 << 20) - (1 << 19));
        send_call(n_elems);
        phase_items += n_elems;
      end
    end
    drain();

    if (sb.mismatches == 0)
      $display("strike_bucket_coupon_select_core: match");
    else
      $display("strike_bucket_coupon_select_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
sv/sbcs_pkg.sv
sv/sbcs_in_if.sv
sv/sbcs_out_if.sv
sv/sbcs_ram.sv
sv/sbcs_muldiv.sv
sv/strike_bucket_coupon_select_core.sv
tb/tb_strike_bucket_coupon_select_core.sv
